FILE: src/rlh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlh_pkg: shared types and constants for the RGB / luma histogram
// Transfer payloads, request and result codes, queue command and FSM types.
// ----------------------------------------------------------------------------
package rlh_pkg;

  // Fixed field widths
  localparam int CHAN_W     = 16;
  localparam int BIN_NUM_W  = 8;
  localparam int COUNT_BITS = 20;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_PIXEL = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Result codes carried in result_kind
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Rec.709 luma weights, Q16, summing to 65536
  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [CHAN_W-1:0] red_value;
    logic signed [CHAN_W-1:0] green_value;
    logic signed [CHAN_W-1:0] blue_value;
    logic                     frame_last;
    logic [BIN_NUM_W-1:0]     read_bin;
  } in_item_t;

  typedef struct packed {
    logic                  result_kind;
    logic [BIN_NUM_W-1:0]  bin_number;
    logic [COUNT_BITS-1:0] red_count;
    logic [COUNT_BITS-1:0] green_count;
    logic [COUNT_BITS-1:0] blue_count;
    logic [COUNT_BITS-1:0] luma_count;
    logic                  data_valid;
  } out_item_t;

  // Operation handed from the front end to the counter engine
  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic                 frame_last;
    logic [BIN_NUM_W-1:0] read_bin;
    logic                 in_range;
  } cmd_t;

  // Counter engine states
  typedef enum logic [2:0] {
    ST_SWEEP  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_PIX_RD = 3'd2,
    ST_PIX_WR = 3'd3,
    ST_RD_RD  = 3'd4,
    ST_RD_OUT = 3'd5
  } state_t;

endpackage

FILE: src/rlh_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlh_fifo: command queue between front end and counter engine
// Small show-ahead FIFO; head entry is visible while not empty.
// ----------------------------------------------------------------------------
module rlh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: src/rlh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlh_front: request intake and bin computation
// Five-stage pipeline: clamp, multiply, sum / channel bins, luma multiply,
// luma bin. Hands one command per accepted request to the queue; code 3 is dropped.
// ----------------------------------------------------------------------------
module rlh_front #(
  parameter int NUM_BINS  = 256,
  parameter int FRAC_BITS = 12,
  localparam int BIN_W = $clog2(NUM_BINS),
  localparam int QW    = $bits(rlh_pkg::cmd_t) + 4 * BIN_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rlh_pkg::in_item_t   in_item,
  input  logic                init_busy,
  output logic                push,
  output logic [QW-1:0]       push_data,
  input  logic                fifo_full
);

  localparam int NSTG = 5;
  localparam int CW   = FRAC_BITS + 1;         // clamped channel
  localparam int YPW  = CW + 16;               // weighted channel
  localparam int YSW  = YPW + 2;               // weighted sum
  localparam int YW   = FRAC_BITS + 17;        // clamped luma sum
  localparam int BMW  = CW + BIN_W;            // channel * (bins-1)
  localparam int LPW  = YW + BIN_W;            // luma * (bins-1)
  localparam int RBW  = BIN_W + rlh_pkg::BIN_NUM_W;

  localparam logic [15:0]      ONE_IN  = 16'(1 << FRAC_BITS);
  localparam logic [BIN_W-1:0] BIN_MAX = BIN_W'(NUM_BINS - 1);
  localparam logic [YW-1:0]    Y_MAX   = {1'b1, {(YW - 1){1'b0}}};
  localparam logic [BMW:0]     HALF_C  = (BMW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [LPW:0]     HALF_L  = (LPW + 1)'(1) << (FRAC_BITS + 15);

  function automatic logic [CW-1:0] clamp_ch(input logic signed [15:0] v);
    logic [15:0] u;
    u = v;
    if (u[15]) begin
      u = '0;
    end else if (u > ONE_IN) begin
      u = ONE_IN;
    end
    return u[CW-1:0];
  endfunction

  function automatic logic [BIN_W-1:0] chan_bin(input logic [BMW-1:0] p);
    logic [BMW:0] t;
    t = ((BMW + 1)'(p) + HALF_C) >> FRAC_BITS;
    return (t > (BMW + 1)'(BIN_MAX)) ? BIN_MAX : t[BIN_W-1:0];
  endfunction

  function automatic logic [BIN_W-1:0] luma_quant(input logic [LPW-1:0] p);
    logic [LPW:0] t;
    t = ((LPW + 1)'(p) + HALF_L) >> (FRAC_BITS + 16);
    return (t > (LPW + 1)'(BIN_MAX)) ? BIN_MAX : t[BIN_W-1:0];
  endfunction

  // Control shift line
  logic          v_r    [NSTG];
  rlh_pkg::cmd_t cmd_r  [NSTG];
  logic [BIN_W-1:0] addr_r [NSTG];

  // Datapath
  logic [CW-1:0]    ch1_r [3];
  logic [YPW-1:0]   py2_r [3];
  logic [BMW-1:0]   pb2_r [3];
  logic [YW-1:0]    y3_r;
  logic [BIN_W-1:0] cb3_r [3];
  logic [LPW-1:0]   pl4_r;
  logic [BIN_W-1:0] cb4_r [3];
  logic [BIN_W-1:0] lane5_r [4];

  logic                en;
  logic                accept;
  rlh_pkg::cmd_t       cmd_in;
  logic                v_in;
  logic [RBW-1:0]      rb_ext;
  logic [15:0]         w_sel [3];
  logic [YSW-1:0]      y_sum;
  logic [YW-1:0]       y_clamp;

  assign en       = !v_r[NSTG-1] || !fifo_full;
  assign in_stall = !en || init_busy;
  assign accept   = in_valid && !in_stall;
  assign push     = v_r[NSTG-1] && !fifo_full;
  assign push_data = {cmd_r[NSTG-1], lane5_r[3], lane5_r[2], lane5_r[1], lane5_r[0]};

  assign w_sel[0] = rlh_pkg::W_RED;
  assign w_sel[1] = rlh_pkg::W_GREEN;
  assign w_sel[2] = rlh_pkg::W_BLUE;

  always_comb begin
    rb_ext            = RBW'(in_item.read_bin);
    cmd_in.frame_last = in_item.frame_last;
    cmd_in.read_bin   = in_item.read_bin;
    cmd_in.in_range   = (rb_ext < RBW'(NUM_BINS));
    v_in              = 1'b1;
    case (in_item.req_type)
      rlh_pkg::REQ_PIXEL: cmd_in.op = rlh_pkg::OP_PIXEL;
      rlh_pkg::REQ_READ:  cmd_in.op = rlh_pkg::OP_READ;
      rlh_pkg::REQ_CLEAR: cmd_in.op = rlh_pkg::OP_CLEAR;
      default: begin
        cmd_in.op = rlh_pkg::OP_CLEAR;
        v_in      = 1'b0;     // unused code: dropped
      end
    endcase
  end

  always_comb begin
    y_sum   = YSW'(py2_r[0]) + YSW'(py2_r[1]) + YSW'(py2_r[2]);
    y_clamp = (y_sum > YSW'(Y_MAX)) ? Y_MAX : y_sum[YW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) begin
        v_r[s] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= accept && v_in;
      for (int s = 1; s < NSTG; s++) begin
        v_r[s] <= v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r[0]  <= cmd_in;
      addr_r[0] <= rb_ext[BIN_W-1:0];
      for (int s = 1; s < NSTG; s++) begin
        cmd_r[s]  <= cmd_r[s-1];
        addr_r[s] <= addr_r[s-1];
      end
      ch1_r[0] <= clamp_ch(in_item.red_value);
      ch1_r[1] <= clamp_ch(in_item.green_value);
      ch1_r[2] <= clamp_ch(in_item.blue_value);
      for (int c = 0; c < 3; c++) begin
        py2_r[c] <= YPW'(ch1_r[c]) * YPW'(w_sel[c]);
        pb2_r[c] <= BMW'(ch1_r[c]) * BMW'(BIN_MAX);
        cb3_r[c] <= chan_bin(pb2_r[c]);
        cb4_r[c] <= cb3_r[c];
      end
      y3_r  <= y_clamp;
      pl4_r <= LPW'(y3_r) * LPW'(BIN_MAX);
      if (cmd_r[3].op == rlh_pkg::OP_READ) begin
        for (int l = 0; l < 4; l++) begin
          lane5_r[l] <= addr_r[3];
        end
      end else begin
        lane5_r[0] <= cb4_r[0];
        lane5_r[1] <= cb4_r[1];
        lane5_r[2] <= cb4_r[2];
        lane5_r[3] <= luma_quant(pl4_r);
      end
    end
  end

endmodule

FILE: src/rlh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlh_back: counter engine
// Four counter memories with read-then-write-back updates, clearing sweep,
// bin read-out and the result register.
// ----------------------------------------------------------------------------
module rlh_back #(
  parameter int NUM_BINS = 256,
  localparam int BIN_W = $clog2(NUM_BINS),
  localparam int QW    = $bits(rlh_pkg::cmd_t) + 4 * BIN_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [QW-1:0]       pop_data,
  input  logic                empty,
  output logic                pop,
  output logic                init_busy,
  output logic                out_valid,
  input  logic                out_stall,
  output rlh_pkg::out_item_t  out_item
);

  localparam int CMD_W = $bits(rlh_pkg::cmd_t);
  localparam int CB    = rlh_pkg::COUNT_BITS;
  localparam logic [BIN_W-1:0] BIN_MAX   = BIN_W'(NUM_BINS - 1);
  localparam logic [CB-1:0]    COUNT_MAX = '1;

  rlh_pkg::state_t   state_r, state_nxt;
  rlh_pkg::cmd_t     cur_cmd_r;
  rlh_pkg::cmd_t     head_cmd;
  logic [BIN_W-1:0]  cur_bin_r [4];
  logic [CB-1:0]     rd_data_r [4];
  logic [CB-1:0]     wr_data   [4];
  logic [BIN_W-1:0]  wr_addr   [4];
  logic [BIN_W-1:0]  sweep_cnt_r, sweep_cnt_nxt;
  logic              filled_r, filled_nxt;
  logic              init_busy_r, init_busy_nxt;
  logic              out_valid_r;
  rlh_pkg::out_item_t out_item_r;
  rlh_pkg::out_item_t load_item;
  logic              load_out;
  logic              can_take;
  logic              head_needs_out;
  logic              mem_we;
  logic              wr_sweep;

  assign head_cmd  = rlh_pkg::cmd_t'(pop_data[QW-1 -: CMD_W]);
  assign init_busy = init_busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    head_needs_out = (head_cmd.op == rlh_pkg::OP_READ) ||
                     ((head_cmd.op == rlh_pkg::OP_PIXEL) && head_cmd.frame_last);
  end

  always_comb begin
    state_nxt     = state_r;
    sweep_cnt_nxt = sweep_cnt_r;
    filled_nxt    = filled_r;
    init_busy_nxt = init_busy_r;
    can_take      = 1'b0;
    mem_we        = 1'b0;
    wr_sweep      = 1'b0;
    load_out      = 1'b0;
    pop           = 1'b0;
    load_item     = '0;
    case (state_r)
      rlh_pkg::ST_SWEEP: begin
        mem_we   = 1'b1;
        wr_sweep = 1'b1;
        if (sweep_cnt_r == BIN_MAX) begin
          sweep_cnt_nxt = '0;
          init_busy_nxt = 1'b0;
          state_nxt     = rlh_pkg::ST_IDLE;
        end else begin
          sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        end
      end
      rlh_pkg::ST_IDLE: begin
        can_take = 1'b1;
      end
      rlh_pkg::ST_PIX_RD: begin
        state_nxt = rlh_pkg::ST_PIX_WR;
      end
      rlh_pkg::ST_PIX_WR: begin
        mem_we     = 1'b1;
        filled_nxt = 1'b1;
        if (cur_cmd_r.frame_last) begin
          load_out              = 1'b1;
          load_item.result_kind = rlh_pkg::KIND_DONE;
          load_item.data_valid  = 1'b1;
        end
        can_take  = 1'b1;
        state_nxt = rlh_pkg::ST_IDLE;
      end
      rlh_pkg::ST_RD_RD: begin
        state_nxt = rlh_pkg::ST_RD_OUT;
      end
      rlh_pkg::ST_RD_OUT: begin
        load_out              = 1'b1;
        load_item.result_kind = rlh_pkg::KIND_READ;
        load_item.bin_number  = cur_cmd_r.read_bin;
        load_item.data_valid  = filled_r;
        if (cur_cmd_r.in_range) begin
          load_item.red_count   = rd_data_r[0];
          load_item.green_count = rd_data_r[1];
          load_item.blue_count  = rd_data_r[2];
          load_item.luma_count  = rd_data_r[3];
        end
        can_take  = 1'b1;
        state_nxt = rlh_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rlh_pkg::ST_IDLE;
      end
    endcase

    // next command; one that produces a result waits for a free result slot
    if (can_take && !empty && (!head_needs_out || (!out_valid_r && !load_out))) begin
      pop = 1'b1;
      case (head_cmd.op)
        rlh_pkg::OP_PIXEL: state_nxt = rlh_pkg::ST_PIX_RD;
        rlh_pkg::OP_READ:  state_nxt = rlh_pkg::ST_RD_RD;
        rlh_pkg::OP_CLEAR: begin
          state_nxt     = rlh_pkg::ST_SWEEP;
          sweep_cnt_nxt = '0;
          filled_nxt    = 1'b0;
        end
        default: state_nxt = rlh_pkg::ST_IDLE;
      endcase
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      wr_addr[l] = wr_sweep ? sweep_cnt_r : cur_bin_r[l];
      if (wr_sweep) begin
        wr_data[l] = '0;
      end else if (rd_data_r[l] == COUNT_MAX) begin
        wr_data[l] = rd_data_r[l];
      end else begin
        wr_data[l] = rd_data_r[l] + 1'b1;
      end
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [CB-1:0] mem [NUM_BINS];

    always_ff @(posedge clk) begin
      if (mem_we) begin
        mem[wr_addr[l]] <= wr_data[l];
      end
      rd_data_r[l] <= mem[cur_bin_r[l]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlh_pkg::ST_SWEEP;
      sweep_cnt_r <= '0;
      filled_r    <= 1'b0;
      init_busy_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      filled_r    <= filled_nxt;
      init_busy_r <= init_busy_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_cmd_r <= head_cmd;
      for (int l = 0; l < 4; l++) begin
        cur_bin_r[l] <= pop_data[l*BIN_W +: BIN_W];
      end
    end
    if (load_out) begin
      out_item_r <= load_item;
    end
  end

endmodule

FILE: src/rgb_luma_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_luma_histogram: RGB and Rec.709 luma histogram, NUM_BINS bins each
// Pixel, bin-read and clear requests in; bin counts and frame-done out.
// ----------------------------------------------------------------------------
// Each pixel request clamps R, G, B (signed, FRAC_BITS fraction bits) to
// [0, 1.0], forms Rec.709 luma with Q16 weights, quantizes all four values to
// round(x * (NUM_BINS-1)) with halves rounded up, and bumps one saturating
// 20-bit counter in each of four histograms. A read request returns the four
// counts of one bin (zero for a bin past the end) plus the valid mark; the
// last pixel of a frame returns a done transfer once its counts are stored.
// Structure: requests pass through a 5-stage front pipeline into a 4-entry
// queue. The counter engine does a read then a write-back on the counter
// RAMs and takes the next pixel during the write-back; a read holds the
// engine for its RAM read and its result load. A result waits in an output
// register and a request that needs one holds until that register is empty.
// Since the engine spends a read and a write-back on each pixel, a steady
// pixel stream fills the queue and in_stall then rises. A clear request
// zeroes the RAMs one bin per cycle. After reset the same sweep runs with
// in_stall high. Request code 3 is accepted and dropped.
// ----------------------------------------------------------------------------
module rgb_luma_histogram #(
  parameter int NUM_BINS  = 256,
  parameter int FRAC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  rlh_pkg::in_item_t   in_item,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output rlh_pkg::out_item_t  out_item
);

  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int QW     = $bits(rlh_pkg::cmd_t) + 4 * BIN_W;
  localparam int QDEPTH = 4;

  // front end -> queue
  logic          push;
  logic [QW-1:0] push_data;
  logic          fifo_full;
  // queue -> counter engine
  logic          pop;
  logic [QW-1:0] pop_data;
  logic          fifo_empty;
  // engine busy with its post-reset sweep
  logic          init_busy;

  rlh_front #(
    .NUM_BINS  (NUM_BINS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .init_busy (init_busy),
    .push      (push),
    .push_data (push_data),
    .fifo_full (fifo_full)
  );

  rlh_fifo #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (fifo_empty)
  );

  rlh_back #(
    .NUM_BINS (NUM_BINS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_data  (pop_data),
    .empty     (fifo_empty),
    .pop       (pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for rgb_luma_histogram
// Drives pixel, bin-read, clear and unused requests through the valid/stall
// request channel. An in-bench histogram predicts every result transfer, and
// a checker compares each one, field by field, in order. Directed cases come
// first, then randomized traffic with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;

  // Block configuration as instantiated
  localparam int BINS = 256;
  localparam int FRAC = 12;
  localparam int ONE  = 1 << FRAC;          // 1.0 in Q3.12

  // Rec.709 luma weights, Q16
  localparam longint unsigned LUMA_WR = 13933;
  localparam longint unsigned LUMA_WG = 46871;
  localparam longint unsigned LUMA_WB = 4732;

  // Request code with no meaning; the block must drop it
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int MAX_WAIT     = 8;          // longest idle drawn per side
  localparam int QUIET_LIMIT  = 4000;       // cycles with no transfer at all
  localparam int SETTLE       = 40;         // hold-off once results are in
  localparam int RANDOM_ITEMS = 1450;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  rlh_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall = 1'b0;
  rlh_pkg::out_item_t out_item;

  rgb_luma_histogram dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Histogram predictor state
  // --------------------------------------------------------------------------
  logic [rlh_pkg::COUNT_BITS-1:0] red_hist   [BINS];
  logic [rlh_pkg::COUNT_BITS-1:0] green_hist [BINS];
  logic [rlh_pkg::COUNT_BITS-1:0] blue_hist  [BINS];
  logic [rlh_pkg::COUNT_BITS-1:0] luma_hist  [BINS];
  logic                           hist_filled;

  rlh_pkg::out_item_t pending_results[$];    // predicted transfers, oldest first
  int              fail_count;
  bit              no_idle;               // burst mode: neither side idles
  int              stall_left;            // receiver stall cycles still owed
  int              quiet_cycles;
  logic [7:0]      recent_bin;            // last luma bin hit, aims reads

  function automatic void clear_hist();
    for (int i = 0; i < BINS; i++) begin
      red_hist[i]   = '0;
      green_hist[i] = '0;
      blue_hist[i]  = '0;
      luma_hist[i]  = '0;
    end
    hist_filled = 1'b0;
  endfunction

  // Negative -> 0, above 1.0 -> 1.0
  function automatic logic [12:0] clamp_unit(logic signed [15:0] v);
    if (v < 0) return '0;
    if (v > ONE) return 13'(ONE);
    return v[12:0];
  endfunction

  // round(c * 255) with halves rounded up, c in Q12
  function automatic logic [7:0] unit_to_bin(logic [12:0] c);
    int unsigned t;
    t = (int'(c) * (BINS - 1) + (1 << (FRAC - 1))) >> FRAC;
    return (t > BINS - 1) ? 8'(BINS - 1) : t[7:0];
  endfunction

  // Luma sum kept at Q28, quantized straight from full precision
  function automatic logic [7:0] luma_quant(logic [12:0] r, logic [12:0] g, logic [12:0] b);
    longint unsigned y;
    longint unsigned t;
    y = LUMA_WR * r + LUMA_WG * g + LUMA_WB * b;
    if (y > (64'(ONE) << 16)) y = 64'(ONE) << 16;
    t = (y * (BINS - 1) + (64'd1 << (FRAC + 15))) >> (FRAC + 16);
    return (t > BINS - 1) ? 8'(BINS - 1) : t[7:0];
  endfunction

  function automatic logic [rlh_pkg::COUNT_BITS-1:0] sat_inc(
      logic [rlh_pkg::COUNT_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Applies one accepted request to the histogram copy and queues the
  // transfer it must produce, if any.
  function automatic void predict_request(rlh_pkg::in_item_t req);
    logic [12:0] r, g, b;
    logic [7:0]  rb, gb, bb, yb;
    rlh_pkg::out_item_t res;
    res = '0;
    case (req.req_type)
      rlh_pkg::REQ_PIXEL: begin
        r  = clamp_unit(req.red_value);
        g  = clamp_unit(req.green_value);
        b  = clamp_unit(req.blue_value);
        rb = unit_to_bin(r);
        gb = unit_to_bin(g);
        bb = unit_to_bin(b);
        yb = luma_quant(r, g, b);
        red_hist[rb]   = sat_inc(red_hist[rb]);
        green_hist[gb] = sat_inc(green_hist[gb]);
        blue_hist[bb]  = sat_inc(blue_hist[bb]);
        luma_hist[yb]  = sat_inc(luma_hist[yb]);
        hist_filled    = 1'b1;
        recent_bin     = yb;
        // end of frame: done notice with zero counts, valid mark set
        if (req.frame_last) begin
          res.result_kind = rlh_pkg::KIND_DONE;
          res.data_valid  = 1'b1;
          pending_results.push_back(res);
        end
      end
      rlh_pkg::REQ_READ: begin
        // 8-bit index always lands inside 256 bins
        res.result_kind = rlh_pkg::KIND_READ;
        res.bin_number  = req.read_bin;
        res.red_count   = red_hist[req.read_bin];
        res.green_count = green_hist[req.read_bin];
        res.blue_count  = blue_hist[req.read_bin];
        res.luma_count  = luma_hist[req.read_bin];
        res.data_valid  = hist_filled;
        pending_results.push_back(res);
      end
      rlh_pkg::REQ_CLEAR: clear_hist();   // frame_last has no effect here
      default: ;                          // unused code: no result, no change
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall, in-order field check
  // --------------------------------------------------------------------------
  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result(rlh_pkg::out_item_t got);
    rlh_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      fail_count++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("result_kind", want.result_kind, got.result_kind);
    compare_field("bin_number",  want.bin_number,  got.bin_number);
    compare_field("red_count",   want.red_count,   got.red_count);
    compare_field("green_count", want.green_count, got.green_count);
    compare_field("blue_count",  want.blue_count,  got.blue_count);
    compare_field("luma_count",  want.luma_count,  got.luma_count);
    compare_field("data_valid",  want.data_valid,  got.data_valid);
  endfunction

  // After each result transfer, draw how long to hold off the next one. The
  // stall keeps running even with nothing pending, so it lands on every
  // phase of the block's work.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        check_result(out_item);
        stall_left = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog: no transfer on either channel for too long means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  function automatic rlh_pkg::in_item_t make_item(logic [1:0] kind, logic signed [15:0] r,
                                                  logic signed [15:0] g,
                                                  logic signed [15:0] b,
                                                  logic last, logic [7:0] bin);
    rlh_pkg::in_item_t it;
    it.req_type    = kind;
    it.red_value   = r;
    it.green_value = g;
    it.blue_value  = b;
    it.frame_last  = last;
    it.read_bin    = bin;
    return it;
  endfunction

  // One request transfer: optional idle gap, then hold valid until taken.
  // X on in_stall (during reset) counts as a stall.
  task automatic send_item(input rlh_pkg::in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_request(it);
  endtask

  // Sender holds off until every predicted result has come back
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_channel();
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom);                      // any code, sign too
      2: begin
        case ($urandom_range(0, 8))
          0: return 16'sh0000;
          1: return 16'sh0001;
          2: return 16'(ONE - 1);
          3: return 16'(ONE);
          4: return 16'(ONE + 1);
          5: return 16'shFFFF;
          6: return 16'sh8000;
          7: return 16'sh7FFF;
          default: return 16'(ONE / 2);                // rounds half up
        endcase
      end
      default: return 16'($urandom_range(0, ONE));     // inside [0, 1.0]
    endcase
  endfunction

  function automatic logic signed [15:0] any_word();
    return 16'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Stores must come up cleared with the valid mark low
  task automatic test_power_up();
    send_item(make_item(rlh_pkg::REQ_READ, any_word(), any_word(), any_word(), 1'b0, 8'd0));
    send_item(make_item(rlh_pkg::REQ_READ, any_word(), any_word(), any_word(), 1'b0, 8'd255));
  endtask

  // Clamping at both ends, full-scale codes, and the exact half that must
  // round up (0.5 in every channel, which puts luma on a half too)
  task automatic test_quantize_limits();
    send_item(make_item(rlh_pkg::REQ_PIXEL, 16'sh8000, 16'sh7FFF, 16'sh0000, 1'b0, 8'hA5));
    send_item(make_item(rlh_pkg::REQ_PIXEL, 16'(ONE), 16'(ONE + 1), 16'shFFFF, 1'b0, 8'h5A));
    send_item(make_item(rlh_pkg::REQ_PIXEL, 16'(ONE / 2), 16'(ONE / 2), 16'(ONE / 2), 1'b0,
                        8'hFF));
    send_item(make_item(rlh_pkg::REQ_PIXEL, 16'sh0001, 16'(ONE - 1), 16'sh7FFF, 1'b0, 8'h00));
    send_item(make_item(rlh_pkg::REQ_READ, any_word(), any_word(), any_word(), 1'b0, 8'd0));
    send_item(make_item(rlh_pkg::REQ_READ, any_word(), any_word(), any_word(), 1'b0, 8'd128));
    send_item(make_item(rlh_pkg::REQ_READ, any_word(), any_word(), any_word(), 1'b0, 8'd255));
    send_item(make_item(rlh_pkg::REQ_READ, any_word(), any_word(), any_word(), 1'b0,
                        recent_bin));
  endtask

  // Last pixel of a frame gives a done notice; frame_last on a read is inert
  task automatic test_frame_done();
    send_item(make_item(rlh_pkg::REQ_PIXEL, pick_channel(), pick_channel(), pick_channel(),
                        1'b1, 8'($urandom)));
    send_item(make_item(rlh_pkg::REQ_READ, any_word(), any_word(), any_word(), 1'b1,
                        recent_bin));
  endtask

  // Clear zeroes everything and drops the valid mark; frame_last is ignored
  task automatic test_clear();
    send_item(make_item(rlh_pkg::REQ_CLEAR, any_word(), any_word(), any_word(), 1'b1,
                        8'($urandom)));
    send_item(make_item(rlh_pkg::REQ_READ, any_word(), any_word(), any_word(), 1'b0, 8'd128));
    send_item(make_item(rlh_pkg::REQ_PIXEL, 16'(ONE), 16'sh0000, 16'(ONE), 1'b0, 8'd3));
    send_item(make_item(rlh_pkg::REQ_READ, any_word(), any_word(), any_word(), 1'b0, 8'd255));
  endtask

  // Code 3 must leave no trace, even with frame_last set
  task automatic test_unused_code();
    send_item(make_item(REQ_UNUSED, 16'(ONE), 16'(ONE), 16'(ONE), 1'b1, 8'd255));
    send_item(make_item(rlh_pkg::REQ_READ, any_word(), any_word(), any_word(), 1'b0, 8'd255));
    pause_until_drained();
  endtask

  // Mostly pixels, reads aimed at populated bins half the time, rare clears
  // (each costs a full sweep) and a few unused codes. Idling switches off in
  // some 50-item stretches; now and then the sender waits for all results.
  task automatic test_random_traffic();
    int          pick;
    logic [7:0]  bin;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i % 400 == 399) pause_until_drained();
      pick = $urandom_range(0, 99);
      bin  = $urandom_range(0, 1) ? 8'($urandom) : recent_bin;
      if (pick < 70)
        send_item(make_item(rlh_pkg::REQ_PIXEL, pick_channel(), pick_channel(),
                            pick_channel(), ($urandom_range(0, 7) == 0), 8'($urandom)));
      else if (pick < 94)
        send_item(make_item(rlh_pkg::REQ_READ, any_word(), any_word(), any_word(),
                            1'($urandom), bin));
      else if (pick < 96)
        send_item(make_item(rlh_pkg::REQ_CLEAR, any_word(), any_word(), any_word(),
                            1'($urandom), 8'($urandom)));
      else
        send_item(make_item(REQ_UNUSED, any_word(), any_word(), any_word(),
                            1'($urandom), 8'($urandom)));
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    fail_count = 0;
    no_idle    = 1'b0;
    recent_bin = '0;
    clear_hist();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_power_up();
    test_quantize_limits();
    test_frame_done();
    test_clear();
    test_unused_code();
    test_random_traffic();

    // all requests taken: wait out the results, then let the pipe settle so
    // a stray extra transfer still gets caught
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
src/rlh_pkg.sv
src/rlh_fifo.sv
src/rlh_front.sv
src/rlh_back.sv
src/rgb_luma_histogram.sv
test/tb.sv
